FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FET_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fet_pkg.sv
// Shared widths, codes and defaults for the free extent table.
`timescale 1ns / 1ps
package fet_pkg;

    localparam int MAX_EXTENTS_DEF  = 64;
    localparam int HEADER_BYTES_DEF = 24;

    localparam int W_WORD    = 32;
    localparam int W_STATUS  = 2;
    localparam int W_COUNT   = 7;
    localparam int W_CFG_IDX = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [W_STATUS-1:0] ST_OK        = 2'd0;
    localparam logic [W_STATUS-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [W_STATUS-1:0] ST_FULL      = 2'd2;

    localparam logic [W_CFG_IDX-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [W_CFG_IDX-1:0] CFG_HEAP_LIMIT = 1'b1;

endpackage

FILE: sv/fet_req_if.sv
// Request channel: command and operands of one beat.
`timescale 1ns / 1ps
interface fet_req_if import fet_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [W_WORD-1:0]  req_size;
    logic [W_WORD-1:0]  block_addr;
    logic [W_WORD-1:0]  block_len;

    modport source (output valid, output cmd, output req_size, output block_addr,
                    output block_len, input ready);
    modport sink   (input valid, input cmd, input req_size, input block_addr,
                    input block_len, output ready);
endinterface

FILE: sv/fet_rsp_if.sv
// Response channel: status, user address and extent count of one beat.
`timescale 1ns / 1ps
interface fet_rsp_if import fet_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [W_STATUS-1:0]  status;
    logic [W_WORD-1:0]    user_addr;
    logic [W_COUNT-1:0]   extent_count;

    modport source (output valid, output status, output user_addr, output extent_count,
                    input ready);
    modport sink   (input valid, input status, input user_addr, input extent_count,
                    output ready);
endinterface

FILE: sv/fet_alu.sv
// Shared adder with compare and saturation used by the sequencer's add and compare steps.
`timescale 1ns / 1ps
module fet_alu import fet_pkg::*; (
    input  logic [W_WORD:0]    i_a,
    input  logic [W_WORD-1:0]  i_b,
    input  logic [W_WORD-1:0]  i_c,
    output logic [W_WORD+1:0]  o_sum,
    output logic               o_lt,
    output logic               o_gt,
    output logic [W_WORD-1:0]  o_sat
);
    logic [W_WORD+1:0] w_c_ext;

    assign o_sum   = {1'b0, i_a} + {2'b00, i_b};
    assign w_c_ext = {2'b00, i_c};
    assign o_lt    = (o_sum < w_c_ext);
    assign o_gt    = (o_sum > w_c_ext);
    // clamp a grown length at the all-ones word
    assign o_sat   = (|o_sum[W_WORD+1:W_WORD]) ? '1 : o_sum[W_WORD-1:0];
endmodule

FILE: sv/fet_mem.sv
// Extent store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module fet_mem import fet_pkg::*; #(
    parameter int DEPTH = MAX_EXTENTS_DEF,
    parameter int AW    = $clog2(MAX_EXTENTS_DEF),
    parameter int DW    = 2 * W_WORD
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  logic [DW-1:0]  i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output logic [DW-1:0]  o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: sv/coalescing_free_extent_table_core.sv
// Bump-pointer heap with an address-ordered, coalescing free extent table.
// Allocate: two adds on the shared ALU, top plus header, then plus the request size.
// Free: search for the insert slot, right and left merges, tail move; one entry read per
// cycle to search and move, fetch/compare/add per merge.
// One request is worked at a time; the next beat is taken while a response still waits.
// Synchronous active-low reset: limit all ones, heap top zero, table empty.
`timescale 1ns / 1ps
module coalescing_free_extent_table_core import fet_pkg::*; #(
    parameter int MAX_EXTENTS  = MAX_EXTENTS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fet_req_if.sink               i_req,
    fet_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [W_WORD-1:0]     i_cfg_wdata
);
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int DW = 2 * W_WORD;
    localparam logic [CW-1:0]     MAX_CNT = CW'(MAX_EXTENTS);
    localparam logic [CW-1:0]     ONE     = CW'(1);
    localparam logic [W_WORD-1:0] HDR     = W_WORD'(HEADER_BYTES);

    // Sequencer steps. Free: search for the insert slot, merge right, merge
    // left, move the tail of the table, write the merged extent.
    typedef enum logic [3:0] {
        S_IDLE,
        S_A1,     // top + header
        S_A2,     // + request size, check against limit
        S_SRCH,   // stream entries until start >= new address
        S_RM,     // fetch next right neighbour
        S_RM_E,   // does it touch?
        S_RM_A,   // absorb its length
        S_LM,     // fetch next left neighbour
        S_LM_E,   // does it touch?
        S_LM_A,   // absorb into it
        S_SHS,    // set up the tail move
        S_SH,     // move tail, one entry per cycle
        S_WI,     // write merged extent, update count
        S_FIN     // hand result to the output register
    } t_state;

    t_state               r_state;
    logic [W_WORD-1:0]    r_heap_limit;
    logic [W_WORD-1:0]    r_heap_top;
    logic [CW-1:0]        r_used;
    logic [W_WORD-1:0]    r_req_size;
    logic [W_WORD:0]      r_acc;
    logic [W_WORD-1:0]    r_cs;
    logic [W_WORD-1:0]    r_cl;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_ridx;
    logic                 r_pend;
    logic [CW-1:0]        r_r;
    logic [CW-1:0]        r_m;
    logic [CW-1:0]        r_src;
    logic [CW-1:0]        r_dnext;
    logic [CW-1:0]        r_wdst;
    logic [CW-1:0]        r_left;
    logic                 r_dir;
    logic [W_STATUS-1:0]  r_st;
    logic [W_WORD-1:0]    r_ua;
    logic                 r_rsp_valid;
    logic [W_STATUS-1:0]  r_rsp_status;
    logic [W_WORD-1:0]    r_rsp_user;
    logic [W_COUNT-1:0]   r_rsp_count;

    logic                 w_re;
    logic [CW-1:0]        w_raddr;
    logic                 w_we;
    logic [CW-1:0]        w_waddr;
    logic [DW-1:0]        w_wdata;
    logic [DW-1:0]        w_rdata;
    logic [W_WORD-1:0]    w_rd_start;
    logic [W_WORD-1:0]    w_rd_len;
    logic [W_WORD:0]      w_a;
    logic [W_WORD-1:0]    w_b;
    logic [W_WORD-1:0]    w_c;
    logic [W_WORD+1:0]    w_sum;
    logic                 w_lt;
    logic                 w_gt;
    logic [W_WORD-1:0]    w_sat;
    logic [CW+W_COUNT-1:0] w_cnt_wide;

    assign w_rd_start = w_rdata[DW-1:W_WORD];
    assign w_rd_len   = w_rdata[W_WORD-1:0];
    assign w_cnt_wide = {{W_COUNT{1'b0}}, r_used};

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_status;
    assign o_rsp.user_addr    = r_rsp_user;
    assign o_rsp.extent_count = r_rsp_count;

    fet_mem #(
        .DEPTH (MAX_EXTENTS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    fet_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_sum (w_sum),
        .o_lt  (w_lt),
        .o_gt  (w_gt),
        .o_sat (w_sat)
    );

    // Steer memory ports and ALU operands for the current step.
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx;
        w_we    = 1'b0;
        w_waddr = r_wdst;
        w_wdata = w_rdata;
        w_a     = {1'b0, r_cs};
        w_b     = r_cl;
        w_c     = w_rd_start;
        unique case (r_state)
            S_A1: begin
                w_a = {1'b0, r_heap_top};
                w_b = HDR;
            end
            S_A2: begin
                w_a = r_acc;
                w_b = r_req_size;
                w_c = r_heap_limit;
            end
            S_SRCH: begin
                // addr + 0 against the entry start: greater means keep walking
                w_b     = '0;
                w_re    = !(r_pend && !w_gt) && (r_idx != r_used);
                w_raddr = r_idx;
            end
            S_RM: begin
                w_raddr = CW'(r_pos + r_r);
                w_re    = (w_raddr != r_used);
            end
            S_RM_A: begin
                w_a = {1'b0, r_cl};
                w_b = w_rd_len;
            end
            S_LM: begin
                w_re    = (r_pos != r_m);
                w_raddr = CW'(r_pos - r_m - ONE);
            end
            S_LM_E: begin
                w_a = {1'b0, w_rd_start};
                w_b = w_rd_len;
                w_c = r_cs;
            end
            S_LM_A: begin
                w_a = {1'b0, w_rd_len};
                w_b = r_cl;
            end
            S_SH: begin
                // write last cycle's read while fetching the next source
                w_we    = r_pend;
                w_waddr = r_wdst;
                w_wdata = w_rdata;
                w_re    = (r_left != '0);
                w_raddr = r_src;
            end
            S_WI: begin
                w_we    = 1'b1;
                w_waddr = CW'(r_pos - r_m);
                w_wdata = {r_cs, r_cl};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_limit <= '1;
            r_heap_top   <= '0;
            r_used       <= '0;
            r_pend       <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            // base write also rewinds the heap top
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HEAP_BASE:  r_heap_top   <= i_cfg_wdata;
                    CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // load a new beat when the output register frees up, else drop a taken one
            if (r_state == S_FIN && (!r_rsp_valid || o_rsp.ready)) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req_size <= i_req.req_size;
                        r_cs       <= i_req.block_addr;
                        r_cl       <= i_req.block_len;
                        r_idx      <= '0;
                        r_pend     <= 1'b0;
                        r_r        <= '0;
                        r_m        <= '0;
                        r_ua       <= '0;
                        if (i_req.cmd == CMD_ALLOC) begin
                            r_st    <= ST_OK;
                            r_state <= S_A1;
                        end else if (r_used == MAX_CNT) begin
                            // full table: answer, change nothing
                            r_st    <= ST_FULL;
                            r_state <= S_FIN;
                        end else begin
                            r_st    <= ST_OK;
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_A1: begin
                    r_acc   <= w_sum[W_WORD:0];
                    r_state <= S_A2;
                end
                S_A2: begin
                    if (w_gt) begin
                        r_st <= ST_EXHAUSTED;
                    end else begin
                        r_heap_top <= w_sum[W_WORD-1:0];
                        r_ua       <= r_acc[W_WORD-1:0];
                    end
                    r_state <= S_FIN;
                end
                S_SRCH: begin
                    priority if (r_pend && !w_gt) begin
                        r_pos   <= r_ridx;
                        r_state <= S_RM;
                    end else if (r_idx == r_used) begin
                        r_pos   <= r_used;
                        r_state <= S_RM;
                    end else begin
                        r_pend <= 1'b1;
                        r_ridx <= r_idx;
                        r_idx  <= r_idx + ONE;
                    end
                end
                S_RM: begin
                    if (CW'(r_pos + r_r) == r_used) begin
                        r_state <= S_LM;
                    end else begin
                        r_state <= S_RM_E;
                    end
                end
                S_RM_E: begin
                    // neighbour start within reach of our end: absorb it
                    if (!w_lt) begin
                        r_state <= S_RM_A;
                    end else begin
                        r_state <= S_LM;
                    end
                end
                S_RM_A: begin
                    r_cl    <= w_sat;
                    r_r     <= r_r + ONE;
                    r_state <= S_RM;
                end
                S_LM: begin
                    if (r_pos == r_m) begin
                        r_state <= S_SHS;
                    end else begin
                        r_state <= S_LM_E;
                    end
                end
                S_LM_E: begin
                    if (!w_lt) begin
                        r_state <= S_LM_A;
                    end else begin
                        r_state <= S_SHS;
                    end
                end
                S_LM_A: begin
                    r_cl    <= w_sat;
                    r_cs    <= w_rd_start;
                    r_m     <= r_m + ONE;
                    r_state <= S_LM;
                end
                S_SHS: begin
                    // tail = old entries right of the consumed neighbours
                    r_pend <= 1'b0;
                    r_left <= CW'(r_used - r_pos - r_r);
                    if (r_m == '0 && r_r == '0) begin
                        // pure insert: open a slot, move from the top down
                        r_dir   <= 1'b1;
                        r_src   <= CW'(r_used - ONE);
                        r_dnext <= r_used;
                    end else begin
                        // one or more merges: close the gap, move from the bottom up
                        r_dir   <= 1'b0;
                        r_src   <= CW'(r_pos + r_r);
                        r_dnext <= CW'(r_pos - r_m + ONE);
                    end
                    r_state <= S_SH;
                end
                S_SH: begin
                    if (r_left != '0) begin
                        r_pend  <= 1'b1;
                        r_wdst  <= r_dnext;
                        r_left  <= r_left - ONE;
                        if (r_dir) begin
                            r_src   <= r_src - ONE;
                            r_dnext <= r_dnext - ONE;
                        end else begin
                            r_src   <= r_src + ONE;
                            r_dnext <= r_dnext + ONE;
                        end
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_WI;
                    end
                end
                S_WI: begin
                    r_used  <= CW'(r_used + ONE - r_m - r_r);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_status <= r_st;
                        r_rsp_user   <= r_ua;
                        r_rsp_count  <= w_cnt_wide[W_COUNT-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: sv/fet_chk.sv
// Port-level checker for the free extent table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fet_chk import fet_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [W_STATUS-1:0]  i_rsp_status,
    input logic [W_WORD-1:0]    i_rsp_user
);
    `FET_ASSERT_IMPL(a_status_code, i_rsp_valid, i_rsp_status == ST_OK || i_rsp_status == ST_EXHAUSTED || i_rsp_status == ST_FULL, "response status out of range")
    `FET_ASSERT_IMPL(a_user_zero_on_fail, i_rsp_valid && i_rsp_status != ST_OK, i_rsp_user == '0, "failed beat carries a user address")
    `FET_ASSERT_NEXT(a_busy_after_accept, i_req_valid && i_req_ready, !i_req_ready, "request taken while a beat is in work")
    `FET_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_user) && $stable(i_rsp_status), "stalled response beat changed")
endmodule

bind coalescing_free_extent_table_core fet_chk u_fet_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_user   (o_rsp.user_addr)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for the bump-pointer heap and its coalescing free extent table.
module tb;
    import fet_pkg::*;

    localparam int PHASE_ITEMS = 100;   // random beats per register setting
    localparam int LONG_HOLD   = 400;   // cycles the response side holds off once
    localparam int DRAIN_TAIL  = 60;    // cycles watched after the last reply

    localparam logic [W_WORD-1:0]   HDR_WORD = HEADER_BYTES_DEF;
    localparam logic [W_WORD+1:0]   HDR_WIDE = HEADER_BYTES_DEF;

    // One reply beat as the table should produce it.
    typedef struct packed {
        logic [W_STATUS-1:0] status;
        logic [W_WORD-1:0]   user_addr;
        logic [W_COUNT-1:0]  extent_count;
    } reply_t;

    // Mirror of the heap top, the registers and the extent table. Each request
    // beat updates it and queues the reply the block owes for that beat.
    class heap_mirror;
        logic [W_WORD-1:0] base_reg;
        logic [W_WORD-1:0] limit_reg;
        logic [W_WORD-1:0] top;
        logic [W_WORD-1:0] ext_start [MAX_EXTENTS_DEF];
        logic [W_WORD-1:0] ext_len   [MAX_EXTENTS_DEF];
        int                used;
        reply_t            replies_due [$];
        int                fault_count;

        function new();
            base_reg    = '0;
            limit_reg   = '1;
            top         = '0;
            used        = 0;
            fault_count = 0;
        endfunction

        function void write_reg(logic [W_CFG_IDX-1:0] idx, logic [W_WORD-1:0] v);
            if (idx == CFG_HEAP_BASE) begin
                base_reg = v;
                top      = v;
            end else if (idx == CFG_HEAP_LIMIT) begin
                limit_reg = v;
            end
        endfunction

        // End of extent i, one bit wider so it never wraps.
        function logic [W_WORD:0] end_at(int i);
            return {1'b0, ext_start[i]} + {1'b0, ext_len[i]};
        endfunction

        function logic [W_WORD-1:0] sat_sum(logic [W_WORD-1:0] a, logic [W_WORD-1:0] b);
            logic [W_WORD:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[W_WORD] ? '1 : s[W_WORD-1:0];
        endfunction

        function void drop_at(int i);
            int k;
            for (k = i; k + 1 < used; k++) begin
                ext_start[k] = ext_start[k+1];
                ext_len[k]   = ext_len[k+1];
            end
            used--;
        endfunction

        function logic [W_STATUS-1:0] take_free(logic [W_WORD-1:0] a, logic [W_WORD-1:0] l);
            int pos;
            int k;
            if (used >= MAX_EXTENTS_DEF) return ST_FULL;
            // equal start goes in front of the held extent
            pos = 0;
            while (pos < used && a > ext_start[pos]) pos++;
            for (k = used; k > pos; k--) begin
                ext_start[k] = ext_start[k-1];
                ext_len[k]   = ext_len[k-1];
            end
            ext_start[pos] = a;
            ext_len[pos]   = l;
            used++;
            // absorb right neighbours, then fold into left ones
            while (pos + 1 < used && end_at(pos) >= {1'b0, ext_start[pos+1]}) begin
                ext_len[pos] = sat_sum(ext_len[pos], ext_len[pos+1]);
                drop_at(pos + 1);
            end
            while (pos > 0 && {1'b0, ext_start[pos]} <= end_at(pos - 1)) begin
                ext_len[pos-1] = sat_sum(ext_len[pos-1], ext_len[pos]);
                drop_at(pos);
                pos--;
            end
            return ST_OK;
        endfunction

        function void note_request(logic cmd, logic [W_WORD-1:0] req_size,
                                   logic [W_WORD-1:0] addr, logic [W_WORD-1:0] len);
            reply_t          r;
            logic [W_WORD+1:0] new_top;
            r.status    = ST_OK;
            r.user_addr = '0;
            if (cmd == CMD_ALLOC) begin
                new_top = {2'b00, top} + {2'b00, req_size} + HDR_WIDE;
                if (new_top > {2'b00, limit_reg}) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    r.user_addr = top + HDR_WORD;
                    top         = new_top[W_WORD-1:0];
                end
            end else begin
                r.status = take_free(addr, len);
            end
            r.extent_count = used[W_COUNT-1:0];
            replies_due.push_back(r);
        endfunction

        function void flag(string what, logic [W_WORD-1:0] want, logic [W_WORD-1:0] got);
            fault_count++;
            if (fault_count <= 10)
                $display("%0t %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
        endfunction

        function void check_reply(logic [W_STATUS-1:0] st, logic [W_WORD-1:0] ua,
                                  logic [W_COUNT-1:0] cnt);
            reply_t want;
            if (replies_due.size() == 0) begin
                flag("reply beat with nothing pending, user_addr", '0, ua);
                return;
            end
            want = replies_due.pop_front();
            if (st !== want.status)
                flag("status", {{(W_WORD-W_STATUS){1'b0}}, want.status},
                     {{(W_WORD-W_STATUS){1'b0}}, st});
            if (ua !== want.user_addr)
                flag("user_addr", want.user_addr, ua);
            if (cnt !== want.extent_count)
                flag("extent_count", {{(W_WORD-W_COUNT){1'b0}}, want.extent_count},
                     {{(W_WORD-W_COUNT){1'b0}}, cnt});
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [W_CFG_IDX-1:0]  cfg_idx;
    logic [W_WORD-1:0]     cfg_wdata;
    bit                    hold_rsp_req = 1'b0;  // ask the response side for one long hold-off
    bit                    sender_calm  = 1'b0;  // no gaps between request beats
    logic [W_WORD-1:0]     win_base     = '0;    // low address window for random frees
    heap_mirror            mirror;

    fet_req_if req_if ();
    fet_rsp_if rsp_if ();

    coalescing_free_extent_table_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run: every free walking a full
    // table with merges, plus long gaps and stalls on both sides.
    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle cycles after a request beat: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (sender_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Allocation size: small mostly, with exact fits, one-past fits and full-width sizes.
    function automatic logic [W_WORD-1:0] pick_alloc();
        longint            room;
        int                r;
        logic [W_WORD-1:0] q;
        room = longint'(mirror.limit_reg) - longint'(mirror.top) - longint'(HEADER_BYTES_DEF);
        r    = $urandom_range(0, 99);
        q    = $urandom_range(0, 255);
        if (r < 5 && room >= 0)
            q = room[W_WORD-1:0];
        else if (r < 15 && room >= -1)
            q = room[W_WORD-1:0] + 32'd1;
        else if (r < 35 && room > 0)
            q = $urandom_range(0, room[W_WORD-1:0]) >> $urandom_range(0, 31);
        else if (r < 60)
            q = $urandom;
        return q;
    endfunction

    // Free extent steered by the mirror: touch, overlap or just miss a held
    // extent; bridge two neighbours when the table runs high; now and then a
    // full-width length in the top sixteenth of the address space.
    function automatic void pick_free(output logic [W_WORD-1:0] a, output logic [W_WORD-1:0] l);
        int              r;
        int              i;
        int              v;
        logic [W_WORD:0] e;
        r = $urandom_range(0, 99);
        a = win_base + $urandom_range(0, 4095);
        l = $urandom_range(0, 64);
        if (mirror.used >= 48 && r < 70) begin
            i = $urandom_range(0, mirror.used - 2);
            e = mirror.end_at(i);
            if (e <= {1'b0, mirror.ext_start[i+1]}) begin
                a = e[W_WORD-1:0];
                l = mirror.ext_start[i+1] - e[W_WORD-1:0];
            end else begin
                a = mirror.ext_start[i+1];
                l = '0;
            end
        end else if (r < 4) begin
            a = 32'hF000_0000 | ($urandom & 32'h0FFF_FFFF);
            l = $urandom;
        end else if (r < 50 && mirror.used > 0) begin
            i = $urandom_range(0, mirror.used - 1);
            e = mirror.end_at(i);
            v = $urandom_range(0, 3);
            case (v)
                0: if (!e[W_WORD]) a = e[W_WORD-1:0];
                1: if (mirror.ext_start[i] >= l) a = mirror.ext_start[i] - l;
                2: if (!e[W_WORD]) a = mirror.ext_start[i] + (mirror.ext_len[i] >> 1);
                default: if (e < {1'b0, 32'hFFFF_FFFF}) a = e[W_WORD-1:0] + 32'd1;
            endcase
        end
    endfunction

    // Offer one request beat from a falling edge, hold it until taken, then idle for the picked gap, if any.
    task automatic send_request(input logic cmd, input logic [W_WORD-1:0] req_size,
                                input logic [W_WORD-1:0] addr, input logic [W_WORD-1:0] len);
        int gap;
        req_if.cmd        = cmd;
        req_if.req_size   = req_size;
        req_if.block_addr = addr;
        req_if.block_len  = len;
        req_if.valid      = 1'b1;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        mirror.note_request(cmd, req_size, addr, len);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_alloc(input logic [W_WORD-1:0] req_size);
        send_request(CMD_ALLOC, req_size, $urandom, $urandom);
    endtask

    task automatic send_free(input logic [W_WORD-1:0] addr, input logic [W_WORD-1:0] len);
        send_request(CMD_FREE, $urandom, addr, len);
    endtask

    // Stop offering beats until every owed reply is back, then let the block settle.
    task automatic await_replies();
        req_if.valid = 1'b0;
        while (mirror.replies_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [W_CFG_IDX-1:0] idx, input logic [W_WORD-1:0] v);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = v;
        mirror.write_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Check every reply beat on the edge that moves it.
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            mirror.check_reply(rsp_if.status, rsp_if.user_addr, rsp_if.extent_count);
    end

    // Response side: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int stall_left;
        int calm_left;
        int r;
        stall_left   = 0;
        calm_left    = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_rsp_req) begin
                hold_rsp_req = 1'b0;
                stall_left   = LONG_HOLD;
                calm_left    = 0;
            end
            if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else if (calm_left > 0) begin
                rsp_if.ready = 1'b1;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                rsp_if.ready = 1'b1;
                if (r < 8) begin
                    calm_left = $urandom_range(50, 200);
                end else if (r < 12) begin
                    rsp_if.ready = 1'b0;
                    stall_left   = $urandom_range(10, 40) - 1;
                end else if (r < 40) begin
                    rsp_if.ready = 1'b0;
                    stall_left   = $urandom_range(1, 3) - 1;
                end
            end
        end
    end

    initial begin : main_flow
        int                phase;
        int                n;
        int                i;
        int                tries;
        longint            lo;
        longint            hi;
        longint            best_lo;
        longint            best_size;
        longint            mid;
        logic [W_WORD-1:0] a;
        logic [W_WORD-1:0] l;
        logic [W_WORD-1:0] b;
        logic [W_WORD:0]   lim;

        mirror = new();
        // Drive every input known from time zero and hold reset.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_HEAP_BASE;
        cfg_wdata         = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_ALLOC;
        req_if.req_size   = '0;
        req_if.block_addr = '0;
        req_if.block_len  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        write_register(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        write_register(CFG_HEAP_BASE, 32'h0000_0000);
        send_alloc(32'd0);                       // smallest block
        send_alloc(32'hFFFF_FFFF);               // largest size, heap exhausted
        send_alloc(32'd100);
        send_free(32'd1000, 32'd0);              // zero length is held
        send_free(32'd1000, 32'd16);             // equal start goes in front, then merges
        send_free(32'd1016, 32'd8);              // touches left neighbour
        send_free(32'd1100, 32'd50);             // stands alone
        send_free(32'd1090, 32'd10);             // touches right neighbour
        send_free(32'd1020, 32'd100);            // overlaps both sides
        send_free(32'd0, 32'd0);                 // lowest address
        send_free(32'hFFFF_FFF0, 32'hFFFF_FFFF); // end beyond 32 bits
        send_free(32'hFFFF_FFF8, 32'd10);        // merged length saturates
        send_free(32'hFFFF_FFFF, 32'd0);         // highest address
        send_free(32'h5555_5550, 32'h0000_0AAA);
        send_alloc(32'hFFFF_FFFF - mirror.top - HDR_WORD);  // exact fit up to the limit
        send_alloc(32'd0);                       // nothing left
        await_replies();
        write_register(CFG_HEAP_BASE, 32'd100);
        write_register(CFG_HEAP_LIMIT, 32'd123);
        send_alloc(32'd0);                       // header alone passes the limit by one
        await_replies();
        write_register(CFG_HEAP_LIMIT, 32'd124);
        send_alloc(32'd0);                       // header alone lands on the limit
        send_alloc(32'd0);
        await_replies();
        write_register(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        write_register(CFG_HEAP_BASE, 32'hFFFF_FFE8);
        send_alloc(32'd0);                       // top plus header passes 32 bits
        await_replies();
        write_register(CFG_HEAP_BASE, 32'hFFFF_FFE7);
        send_alloc(32'd0);                       // user address all ones
        await_replies();

        // ---- random part, one register setting per phase ----
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_HEAP_BASE, 32'h0000_0000);
                    write_register(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
                end
                1: begin
                    write_register(CFG_HEAP_BASE, 32'h0000_1000);
                    write_register(CFG_HEAP_LIMIT, 32'h0000_1800);
                end
                2: begin
                    b   = $urandom;
                    lim = {1'b0, b} + {1'b0, 32'($urandom_range(0, 16384))};
                    write_register(CFG_HEAP_BASE, b);
                    write_register(CFG_HEAP_LIMIT, lim[W_WORD] ? 32'hFFFF_FFFF : lim[W_WORD-1:0]);
                end
                3: begin
                    write_register(CFG_HEAP_BASE, 32'hFFFF_FF00);
                    write_register(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
                end
                4: begin
                    write_register(CFG_HEAP_BASE, 32'h0000_0000);
                    write_register(CFG_HEAP_LIMIT, 32'h0000_0000);
                end
                default: begin
                    write_register(CFG_HEAP_BASE, 32'hFFFF_FFFF);
                    write_register(CFG_HEAP_LIMIT, 32'h0000_0000);
                end
            endcase
            // move the free window each phase, keeping it below the top sixteenth
            win_base    = 32'($urandom_range(0, 32'h0000_EFFF)) << 16;
            sender_calm = (phase == 1 || phase == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Long hold-off on replies while requests keep coming: the
                // block takes one more beat, then must stall its request side.
                if (phase == 0 && n == 30) hold_rsp_req = 1'b1;
                // Pause the requests until the block has answered everything.
                if (phase == 0 && n == 70) await_replies();
                if ($urandom_range(0, 1) == 0) begin
                    send_alloc(pick_alloc());
                end else begin
                    pick_free(a, l);
                    send_free(a, l);
                end
            end
            await_replies();
        end

        // ---- fill the table, then push frees into it while full ----
        // Drop a one-byte extent in the middle of the widest gap, clear of
        // both neighbours, so that nothing merges and the count climbs.
        tries = 0;
        while (mirror.used < MAX_EXTENTS_DEF && tries < 2 * MAX_EXTENTS_DEF) begin
            tries++;
            best_size = 0;
            best_lo   = 0;
            for (i = -1; i < mirror.used; i++) begin
                lo = (i < 0) ? 64'sd0 : longint'(mirror.end_at(i)) + 1;
                hi = (i == mirror.used - 1) ? 64'sd4294967295
                                            : longint'(mirror.ext_start[i+1]) - 1;
                if (hi - lo > best_size) begin
                    best_size = hi - lo;
                    best_lo   = lo;
                end
            end
            if (best_size < 1) break;
            mid = best_lo + best_size / 2;
            send_free(mid[W_WORD-1:0], 32'd1);
        end
        for (n = 0; n < 3; n++) begin
            pick_free(a, l);                     // would merge, but the table is full
            send_free(a, l);
        end
        send_free($urandom, $urandom);
        send_alloc(pick_alloc());
        send_alloc(32'd0);

        await_replies();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mirror.fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
